### hdl/sfmt19937_generator_unit_assert.svh
// Assertion macros for the SFMT-19937 generator unit.
`ifndef SFMT19937_GENERATOR_UNIT_ASSERT_SVH
`define SFMT19937_GENERATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SFMT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sfmt assertion failed");
`define SFMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfmt assertion failed");
`else
`define SFMT_ASSERT(lbl, prop)
`define SFMT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/sfmt_pkg.sv
// Package with constants, state codes and the block recurrence of the SFMT-19937 unit.
`timescale 1ns / 1ps
`default_nettype none
package sfmt_pkg;
  localparam int unsigned StateWords = 624;
  localparam int unsigned PosW = 22;
  localparam logic [31:0] InitMult = 32'h6C078965;
  localparam logic [31:0] ParityWord3 = 32'h13c9e684;
  localparam logic [31:0] Mask0 = 32'hdfffffef;
  localparam logic [31:0] Mask1 = 32'hddfecb7f;
  localparam logic [31:0] Mask2 = 32'hbffaffff;
  localparam logic [31:0] Mask3 = 32'hbffffff6;
  localparam logic [9:0] MiddleOffset = 10'd488;
  localparam logic [9:0] LastBlock2 = 10'd616;
  localparam logic [9:0] LastBlock1 = 10'd620;
  localparam logic [PosW-1:0] PosWords = PosW'(StateWords);

  localparam logic [1:0] KindSeed = 2'd0;
  localparam logic [1:0] KindNext32 = 2'd1;
  localparam logic [1:0] KindNext64 = 2'd2;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StSeed = 4'd1;
  localparam logic [3:0] StParity = 4'd2;
  localparam logic [3:0] StCheck = 4'd3;
  localparam logic [3:0] StRgLoad = 4'd4;
  localparam logic [3:0] StRgRead = 4'd5;
  localparam logic [3:0] StRgWrite = 4'd6;
  localparam logic [3:0] StDraw = 4'd7;
  localparam logic [3:0] StDrawCap = 4'd8;
  localparam logic [3:0] StDone = 4'd9;

  typedef logic [3:0][31:0] block_t;

  function automatic block_t sfmt_block(block_t a, block_t b, block_t c, block_t d);
    block_t n;
    n[3] = a[3] ^ (a[3] << 8) ^ (a[2] >> 24) ^ (c[3] >> 8)
         ^ ((b[3] >> 11) & Mask3) ^ (d[3] << 18);
    n[2] = a[2] ^ (a[2] << 8) ^ (a[1] >> 24) ^ (c[3] << 24) ^ (c[2] >> 8)
         ^ ((b[2] >> 11) & Mask2) ^ (d[2] << 18);
    n[1] = a[1] ^ (a[1] << 8) ^ (a[0] >> 24) ^ (c[2] << 24) ^ (c[1] >> 8)
         ^ ((b[1] >> 11) & Mask1) ^ (d[1] << 18);
    n[0] = a[0] ^ (a[0] << 8) ^ (c[1] << 24) ^ (c[0] >> 8)
         ^ ((b[0] >> 11) & Mask0) ^ (d[0] << 18);
    return n;
  endfunction
endpackage
`default_nettype wire

### hdl/sfmt19937_generator_unit.sv
// Top level of the SFMT-19937 generator: state memory, seeding and regeneration sequencer.
// A next32 request passes check, draw, capture and done; a next64 request draws twice.
// When no words remain, regeneration loads the last two blocks and rewrites 156 blocks.
// Seeding fills the state and regenerates once, plus once more per 312 skipped frames.
// One transaction is in progress at a time; input is not ready until the previous completes.
// Reset clears control state only; the state memory is undefined until a seed transaction.
`timescale 1ns / 1ps
`default_nettype none
`include "sfmt19937_generator_unit_assert.svh"
module sfmt19937_generator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] seed_value_i,
  input  wire logic [19:0] skip_frames_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      random_value_o
);
  import sfmt_pkg::*;

  logic [31:0] mem [StateWords];
  logic [31:0] rd0_q, rd1_q;
  logic [9:0] ra0, ra1, wa;
  logic [31:0] wd;
  logic we;

  logic [3:0] state_q, state_d;
  logic [1:0] kind_q;
  logic half_q;
  logic [PosW-1:0] pos_q;
  logic [20:0] pos_skip_q;
  logic [9:0] addr_a_q, addr_b_q;
  logic [2:0] step_q;
  logic [31:0] p_q, w0_q, w3_q;
  logic [31:0] lo_q, hi_q;
  block_t a_w_q, b_w_q, c_w_q, d_w_q, new_blk;
  logic [31:0] seed_next;
  logic par;
  logic [9:0] b_inc;
  logic out_valid_q;
  logic [63:0] value_q;
  logic accept;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign random_value_o = value_q;

  assign new_blk = sfmt_block(a_w_q, b_w_q, c_w_q, d_w_q);
  assign seed_next = 32'(InitMult * (p_q ^ (p_q >> 30))) + {22'd0, addr_a_q};
  assign par = ^(({31'd0, w0_q[0]}) ^ (w3_q & ParityWord3));
  assign b_inc = addr_b_q + 10'd4;

  always_comb begin
    ra0 = '0;
    ra1 = '0;
    we = 1'b0;
    wa = '0;
    wd = '0;
    case (state_q)
      StIdle: begin
        we = accept && (kind_i == KindSeed);
        wd = seed_value_i;
      end
      StSeed: begin
        we = 1'b1;
        wa = addr_a_q;
        wd = seed_next;
      end
      StParity: begin
        we = 1'b1;
        wd = w0_q ^ {31'd0, ~par};
      end
      StRgLoad: begin
        ra0 = LastBlock2 + {8'd0, step_q[1:0]};
        ra1 = LastBlock1 + {8'd0, step_q[1:0]};
      end
      StRgRead: begin
        ra0 = addr_a_q + {8'd0, step_q[1:0]};
        ra1 = addr_b_q + {8'd0, step_q[1:0]};
      end
      StRgWrite: begin
        we = 1'b1;
        wa = addr_a_q + {8'd0, step_q[1:0]};
        wd = new_blk[step_q[1:0]];
      end
      StDraw: begin
        ra0 = pos_q[9:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0_q <= mem[ra0];
    rd1_q <= mem[ra1];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (kind_i == KindSeed) begin
            state_d = StSeed;
          end else if (kind_i == KindNext32 || kind_i == KindNext64) begin
            state_d = StCheck;
          end
        end
      end
      StSeed: begin
        if (addr_a_q == 10'(StateWords - 1)) begin
          state_d = StParity;
        end
      end
      StParity: state_d = StCheck;
      StCheck: begin
        if (pos_q >= PosWords) begin
          state_d = StRgLoad;
        end else if (kind_q == KindSeed) begin
          state_d = StIdle;
        end else begin
          state_d = StDraw;
        end
      end
      StRgLoad: begin
        if (step_q == 3'd4) begin
          state_d = StRgRead;
        end
      end
      StRgRead: begin
        if (step_q == 3'd4) begin
          state_d = StRgWrite;
        end
      end
      StRgWrite: begin
        if (step_q == 3'd3) begin
          state_d = (addr_a_q == LastBlock1) ? StCheck : StRgRead;
        end
      end
      StDraw: state_d = StDrawCap;
      StDrawCap: begin
        state_d = (kind_q == KindNext64 && !half_q) ? StCheck : StDone;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q <= PosWords;
      out_valid_q <= 1'b0;
      kind_q <= KindSeed;
      half_q <= 1'b0;
      step_q <= '0;
      addr_a_q <= '0;
      addr_b_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StDone && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            kind_q <= kind_i;
            half_q <= 1'b0;
            addr_a_q <= 10'd1;
          end
        end
        StSeed: addr_a_q <= addr_a_q + 10'd1;
        StParity: pos_q <= PosWords + {1'b0, pos_skip_q};
        StCheck: begin
          step_q <= '0;
          addr_a_q <= '0;
          addr_b_q <= MiddleOffset;
        end
        StRgLoad, StRgRead: begin
          step_q <= (step_q == 3'd4) ? 3'd0 : step_q + 3'd1;
        end
        StRgWrite: begin
          step_q <= (step_q == 3'd3) ? 3'd0 : step_q + 3'd1;
          if (step_q == 3'd3) begin
            addr_a_q <= addr_a_q + 10'd4;
            addr_b_q <= (b_inc >= 10'(StateWords)) ? 10'd0 : b_inc;
            if (addr_a_q == LastBlock1) begin
              pos_q <= pos_q - PosWords;
            end
          end
        end
        StDraw: pos_q <= pos_q + 22'd1;
        StDrawCap: half_q <= 1'b1;
        default: begin
          step_q <= step_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && kind_i == KindSeed) begin
      p_q <= seed_value_i;
      w0_q <= seed_value_i;
      pos_skip_q <= {skip_frames_i, 1'b0};
    end
    if (state_q == StSeed) begin
      p_q <= seed_next;
      if (addr_a_q == 10'd3) begin
        w3_q <= seed_next;
      end
    end
    if (state_q == StRgLoad && step_q != 3'd0) begin
      c_w_q[step_q[1:0] - 2'd1] <= rd0_q;
      d_w_q[step_q[1:0] - 2'd1] <= rd1_q;
    end
    if (state_q == StRgRead && step_q != 3'd0) begin
      a_w_q[step_q[1:0] - 2'd1] <= rd0_q;
      b_w_q[step_q[1:0] - 2'd1] <= rd1_q;
    end
    if (state_q == StRgWrite && step_q == 3'd3) begin
      c_w_q <= d_w_q;
      d_w_q <= new_blk;
    end
    if (state_q == StDrawCap) begin
      if (half_q) begin
        hi_q <= rd0_q;
      end else begin
        lo_q <= rd0_q;
      end
    end
    if (state_q == StDone && (!out_valid_q || out_ready_i)) begin
      value_q <= (kind_q == KindNext64) ? {hi_q, lo_q} : {32'd0, lo_q};
    end
  end

  `SFMT_ASSERT(a_draw_pos, (state_q == StDraw) |-> (pos_q < PosWords))
  `SFMT_ASSERT(a_regen_addr, (state_q == StRgRead) |-> (addr_a_q < 10'(StateWords) && addr_b_q < 10'(StateWords)))
  `SFMT_ASSERT_NEXT(a_regen_end, state_q == StRgWrite && step_q == 3'd3 && addr_a_q == LastBlock1, state_q == StCheck)
  `SFMT_ASSERT(a_out_src, $rose(out_valid_q) |-> ($past(state_q) == StDone))
endmodule
`default_nettype wire
